>>> hdl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int KeyIdxW   = 1;

  typedef enum logic [KeyIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [127:0] block_t;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one round: state and key as four big-endian columns, column 0 in [127:96]
  function automatic block_t aes_round(input block_t st, input block_t rk, input logic mix);
    logic [7:0] b [4];
    logic [7:0] m [4];
    logic [7:0] all;
    block_t     res;
    res = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b[r] = SBOX[st[127 - 32*((c + r) % 4) - 8*r -: 8]];
      end
      all = b[0] ^ b[1] ^ b[2] ^ b[3];
      for (int r = 0; r < 4; r++) begin
        m[r] = mix ? (b[r] ^ all ^ xtime(b[r] ^ b[(r + 1) % 4])) : b[r];
      end
      res[127 - 32*c -: 32] = {m[0], m[1], m[2], m[3]} ^ rk[127 - 32*c -: 32];
    end
    aes_round = res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/aes128_block_encrypt_core.sv
`default_nettype none
// Pipeline: 11 register stages (key add + 10 rounds); a block moves from the key-add
// register through the round registers in order, holding whenever the output stalls.
// Throughput: one block per cycle while the output is accepted and no key expansion runs; one register stage per round.
// Key write: input held off while the schedule re-expands, one round key per cycle.
// Reset (rst_n low, synchronous): pipeline emptied, key cleared to zero, input held off
// after release while the zero-key schedule expands.
module aes128_block_encrypt_core
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_idx,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // plain_high [63:0], plain_low [127:64]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata  // cipher_high [63:0], cipher_low [127:64]
);

  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic        kstart_r;
  logic        ks_busy;
  block_t      rkeys [NumRounds+1];
  logic        vld   [NumRounds+1];
  block_t      st    [NumRounds+1];
  logic        en;
  logic        vld0_r;
  block_t      st0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      kstart_r <= 1'b0;
    end else begin
      kstart_r <= cfg_we;
      if (cfg_we && cfg_idx == REG_KEY_HIGH) key_hi_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_KEY_LOW)  key_lo_r <= cfg_wdata;
    end
  end

  aes_key_sched u_ks (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kstart_r),
    .key   ({key_hi_r, key_lo_r}),
    .busy  (ks_busy),
    .rkeys (rkeys)
  );

  // advance when the output slot is free or empty
  assign en        = !vld[NumRounds] || out_tready;
  assign in_tready = en && !kstart_r && !ks_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r <= {in_tdata[63:0], in_tdata[127:64]} ^ rkeys[0];
    end
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round_stage u_rs (
      .clk     (clk),
      .rst_n   (rst_n),
      .mix     (g != NumRounds),
      .en      (en),
      .in_vld  (vld[g-1]),
      .in_st   (st[g-1]),
      .rk      (rkeys[g]),
      .out_vld (vld[g]),
      .out_st  (st[g])
    );
  end

  assign out_tvalid = vld[NumRounds];
  assign out_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

endmodule
`default_nettype wire

>>> hdl/aes_key_sched.sv
`default_nettype none
// Expands one round key per cycle after a key write or a reset; keys held in flops.
module aes_key_sched
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  output logic              busy,
  output block_t            rkeys [NumRounds+1]
);

  block_t     rk_r [NumRounds+1];
  logic [3:0] cnt_r;
  logic [7:0] rcon_r;
  logic       busy_r;
  block_t     prev;
  block_t     nk;
  logic [31:0] t;

  always_comb begin
    prev = rk_r[cnt_r - 4'd1];
    t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'h0};
    nk[127:96] = prev[127:96] ^ t;
    nk[95:64]  = prev[95:64]  ^ nk[127:96];
    nk[63:32]  = prev[63:32]  ^ nk[95:64];
    nk[31:0]   = prev[31:0]   ^ nk[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      rk_r[0] <= rst_n ? key : '0;
      cnt_r   <= 4'd1;
      rcon_r  <= 8'h01;
      busy_r  <= 1'b1;
    end else if (busy_r) begin
      rk_r[cnt_r] <= nk;
      rcon_r      <= xtime(rcon_r);
      cnt_r       <= cnt_r + 4'd1;
      busy_r      <= (cnt_r != 4'(NumRounds));
    end
  end

  assign busy  = busy_r;
  assign rkeys = rk_r;

endmodule
`default_nettype wire

>>> hdl/aes_round_stage.sv
`default_nettype none
// One pipeline stage: a full or final AES round with stall support.
module aes_round_stage
  import aes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   mix,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  wire block_t in_st,
  input  wire block_t rk,
  output logic        out_vld,
  output block_t      out_st
);

  logic   vld_r;
  block_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= aes_round(in_st, rk, mix);
    end
  end

  assign out_vld = vld_r;
  assign out_st  = st_r;

endmodule
`default_nettype wire
